// ===== hw/rtl/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared constants, request and status codes, and controller command type
// for the circular FIFO queue core.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W    = 3;
    localparam int IDX_W    = 8;
    localparam int CNT_W    = 9;
    localparam int STAT_W   = 2;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    // capacity register reset value, also used when the register holds zero
    localparam logic [CNT_W-1:0] CAP_RESET = 9'd200;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK_F = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PEEK_B = 3'd3;
    localparam logic [REQ_W-1:0] REQ_OFFSET = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request word
        logic exec;     // run the request against the queue state
        logic respond;  // result on the output ports
    } t_cmd;

endpackage

// ===== hw/rtl/cfq_ram.sv =====
// ----------------------------------------------------------------------------
// cfq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module cfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/cfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfq_ctrl
// Request sequencer: accept, execute (store access), respond.
// ----------------------------------------------------------------------------
module cfq_ctrl import cfq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign busy     = (r_state == S_EXEC);
    assign w_accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE, S_DONE: begin
                n_state = w_accept ? S_EXEC : S_IDLE;
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load    = w_accept;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.respond = (r_state == S_DONE);

endmodule

// ===== hw/rtl/cfq_datapath.sv =====
// ----------------------------------------------------------------------------
// cfq_datapath
// Queue pointers, fill count, slot arithmetic and the entry store.
// ----------------------------------------------------------------------------
module cfq_datapath import cfq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic [CNT_W-1:0]      i_cap_limit,
    output logic [DATA_WIDTH-1:0] o_read_data,
    output logic [STAT_W-1:0]     o_status,
    output logic [CNT_W-1:0]      o_fill_count
);

    localparam int AW = $clog2(DEPTH);
    // slot sums: head + offset, count vs capacity
    localparam int SW = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);

    logic [REQ_W-1:0]      r_req;
    logic [DATA_WIDTH-1:0] r_wdata;
    logic [IDX_W-1:0]      r_idx;
    logic [AW-1:0]         r_head,   n_head;
    logic [AW-1:0]         r_tail,   n_tail;
    logic [CNT_W-1:0]      r_count,  n_count;
    logic [STAT_W-1:0]     r_status, n_status;
    logic                  r_hit,    n_hit;

    logic [CNT_W-1:0]      w_cap_raw;
    logic [SW-1:0]         w_cap;
    logic [SW-1:0]         w_count_s;
    logic [SW-1:0]         w_head_inc;
    logic [SW-1:0]         w_tail_inc;
    logic [AW-1:0]         w_head_adv;
    logic [AW-1:0]         w_tail_adv;
    logic [SW-1:0]         w_off_sum;
    logic [SW-1:0]         w_off_wrap;
    logic [SW-1:0]         w_off_mod;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [DATA_WIDTH-1:0] w_q;

    // effective capacity: zero means default, clamp to store depth
    assign w_cap_raw = (i_cap_limit == '0) ? CAP_RESET : i_cap_limit;
    assign w_cap     = (SW'(w_cap_raw) > DEPTH_S) ? DEPTH_S : SW'(w_cap_raw);
    assign w_count_s = SW'(r_count);

    assign w_head_inc = SW'(r_head) + SW'(1);
    assign w_tail_inc = SW'(r_tail) + SW'(1);
    assign w_head_adv = (w_head_inc >= w_cap) ? '0 : w_head_inc[AW-1:0];
    assign w_tail_adv = (w_tail_inc >= w_cap) ? '0 : w_tail_inc[AW-1:0];

    // offset slot: wrap once at capacity, then fold into the store
    assign w_off_sum  = SW'(r_head) + SW'(r_idx);
    assign w_off_wrap = (w_off_sum >= w_cap) ? (w_off_sum - w_cap) : w_off_sum;
    assign w_off_mod  = (w_off_wrap >= DEPTH_S) ? (w_off_wrap - DEPTH_S) : w_off_wrap;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_status = r_status;
        n_hit    = r_hit;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        w_raddr  = r_head;
        if (i_cmd.exec) begin
            n_status = ST_OK;
            n_hit    = 1'b0;
            unique case (r_req)
                REQ_PUSH: begin
                    if (w_count_s >= w_cap) begin
                        n_status = ST_FULL;
                    end else begin
                        if (r_count != '0) begin
                            w_waddr = w_tail_adv;
                        end
                        w_we    = 1'b1;
                        n_tail  = w_waddr;
                        n_count = r_count + 1'b1;
                    end
                end
                REQ_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_hit = 1'b1;
                        if (r_count > CNT_W'(1)) begin
                            n_head = w_head_adv;
                        end
                        n_count = r_count - 1'b1;
                    end
                end
                REQ_PEEK_F: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_hit = 1'b1;
                    end
                end
                REQ_PEEK_B: begin
                    w_raddr = r_tail;
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_hit = 1'b1;
                    end
                end
                REQ_OFFSET: begin
                    w_raddr = w_off_mod[AW-1:0];
                    if (CNT_W'(r_idx) >= r_count) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_hit = 1'b1;
                    end
                end
                default: begin
                    // unknown request: no effect, ok status
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req   <= i_req_type;
            r_wdata <= i_push_data;
            r_idx   <= i_entry_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
            r_hit    <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_status <= n_status;
            r_hit    <= n_hit;
        end
    end

    cfq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q)
    );

    // outputs are valid while the controller is responding
    assign o_read_data  = (i_cmd.respond && r_hit) ? w_q : '0;
    assign o_status     = r_status;
    assign o_fill_count = r_count;

endmodule

// ===== hw/rtl/circular_fifo_queue_core.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue_core
// Ring-buffer FIFO with register-set capacity; push, pop, peek and offset read.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive i_req_type, i_push_data, i_entry_index with start
//   high; the request is taken on a clock edge where busy is low.
//   Result channel: o_result_valid pulses for one cycle with o_read_data,
//   o_status and o_fill_count. The receiver must take it in that cycle.
//   Order: the accepted request goes through the execute state, which
//   accesses the entry store, and its registered read data reach the
//   ports in the respond state that follows.
//   A new request can be taken while the previous result is on the
//   ports; busy is high for the execute cycle after each accept.
//   Config: APB register 0 (capacity_limit, 9 bits), paddr not decoded;
//   write only while no request is in flight. pready is always high.
//   Reset: queue empty, head and tail at slot 0, capacity_limit = 200.
//   Store contents are not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module circular_fifo_queue_core import cfq_pkg::*; #(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [DATA_WIDTH-1:0] i_push_data,
    input  logic [IDX_W-1:0]      i_entry_index,
    output logic                  o_result_valid,
    output logic [DATA_WIDTH-1:0] o_read_data,
    output logic [STAT_W-1:0]     o_status,
    output logic [CNT_W-1:0]      o_fill_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready
);

    t_cmd             w_cmd;
    logic [CNT_W-1:0] r_cap_limit;
    logic             w_cfg_wr;

    // single register, seen at every paddr; the address is not decoded
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = APB_DW'(r_cap_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_limit <= CAP_RESET;
        end else if (w_cfg_wr) begin
            r_cap_limit <= pwdata[CNT_W-1:0];
        end
    end

    cfq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    cfq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_req_type),
        .i_push_data   (i_push_data),
        .i_entry_index (i_entry_index),
        .i_cap_limit   (r_cap_limit),
        .o_read_data   (o_read_data),
        .o_status      (o_status),
        .o_fill_count  (o_fill_count)
    );

    assign o_result_valid = w_cmd.respond;

endmodule

// ===== hw/rtl/cfq_checker.sv =====
// ----------------------------------------------------------------------------
// cfq_props
// Port-level checks of request/result timing and result consistency.
// ----------------------------------------------------------------------------
module cfq_props import cfq_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_result_valid,
    input logic [DATA_WIDTH-1:0] o_read_data,
    input logic [STAT_W-1:0]     o_status,
    input logic [CNT_W-1:0]      o_fill_count
);

    // every accepted request gets exactly one result, after its execute state
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_result_valid)
        else $error("missing result two cycles after accept");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 2))
        else $error("result without an accepted request");

    a_error_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("failed request returned nonzero data");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == ST_FULL) |-> (o_fill_count != '0))
        else $error("full status with empty queue");

endmodule

bind circular_fifo_queue_core cfq_props #(
    .DATA_WIDTH (DATA_WIDTH)
) u_cfq_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_read_data    (o_read_data),
    .o_status       (o_status),
    .o_fill_count   (o_fill_count)
);

// ===== verif/cfq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfq_checker
// Watches the request, result and register channels of the circular FIFO
// queue core, keeps its own copy of the queue and compares every result word.
// ----------------------------------------------------------------------------
module cfq_checker import cfq_pkg::*; #(
    parameter logic [APB_AW-1:0] CAP_ADDR = '0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [31:0]           i_push_data,
    input  logic [IDX_W-1:0]      i_entry_index,
    input  logic                  o_result_valid,
    input  logic [31:0]           o_read_data,
    input  logic [STAT_W-1:0]     o_status,
    input  logic [CNT_W-1:0]      o_fill_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    input  logic [APB_DW-1:0]     prdata,
    input  logic                  pready,
    output int unsigned           o_errors,
    output int unsigned           o_pending
);

    typedef struct packed {
        logic [31:0]       read_data;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  fill;
    } queue_reply_t;

    logic [31:0]      entry_copy [DEPTH_DEF];
    int unsigned      head_slot;
    int unsigned      tail_slot;
    int unsigned      entry_count;
    logic [CNT_W-1:0] cap_reg;
    queue_reply_t     replies_due [$];
    queue_reply_t     want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        for (int i = 0; i < DEPTH_DEF; i++) entry_copy[i] = '0;
    end

    task automatic note_error(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        o_errors++;
    endtask

    function automatic int unsigned next_slot(input int unsigned slot, input int unsigned cap);
        return (slot + 1 >= cap) ? 0 : slot + 1;
    endfunction

    // zero means the reset capacity; anything above the store depth is clipped
    function automatic int unsigned live_capacity();
        if (cap_reg == '0) return int'(CAP_RESET);
        if (int'(cap_reg) > DEPTH_DEF) return DEPTH_DEF;
        return int'(cap_reg);
    endfunction

    function automatic queue_reply_t apply_request(input logic [REQ_W-1:0] rt,
                                                   input logic [31:0] word,
                                                   input logic [IDX_W-1:0] idx);
        queue_reply_t r;
        int unsigned  cap;
        int unsigned  slot;
        cap = live_capacity();
        r.read_data = '0;
        r.status    = ST_OK;
        case (rt)
            REQ_PUSH: begin
                if (entry_count >= cap) begin
                    r.status = ST_FULL;
                end else begin
                    if (entry_count > 0) tail_slot = next_slot(tail_slot, cap);
                    entry_copy[tail_slot % DEPTH_DEF] = word;
                    entry_count++;
                end
            end
            REQ_POP: begin
                if (entry_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_data = entry_copy[head_slot % DEPTH_DEF];
                    if (entry_count > 1) head_slot = next_slot(head_slot, cap);
                    entry_count--;
                end
            end
            REQ_PEEK_F: begin
                if (entry_count == 0) r.status = ST_EMPTY;
                else r.read_data = entry_copy[head_slot % DEPTH_DEF];
            end
            REQ_PEEK_B: begin
                if (entry_count == 0) r.status = ST_EMPTY;
                else r.read_data = entry_copy[tail_slot % DEPTH_DEF];
            end
            REQ_OFFSET: begin
                if (int'(idx) >= entry_count) begin
                    r.status = ST_EMPTY;
                end else begin
                    // wraps once at the capacity, then at the store depth
                    slot = head_slot + idx;
                    if (slot >= cap) slot -= cap;
                    r.read_data = entry_copy[slot % DEPTH_DEF];
                end
            end
            default: ;
        endcase
        r.fill = entry_count[CNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_slot   = 0;
            tail_slot   = 0;
            entry_count = 0;
            cap_reg     = CAP_RESET;
            replies_due.delete();
        end else begin
            if (o_result_valid) begin
                if (replies_due.size() == 0) begin
                    note_error("result word with no request outstanding");
                end else begin
                    want = replies_due.pop_front();
                    if (o_read_data !== want.read_data)
                        note_error($sformatf("read_data: expected %08h, got %08h",
                                             want.read_data, o_read_data));
                    if (o_status !== want.status)
                        note_error($sformatf("status: expected %0d, got %0d",
                                             want.status, o_status));
                    if (o_fill_count !== want.fill)
                        note_error($sformatf("fill_count: expected %0d, got %0d",
                                             want.fill, o_fill_count));
                end
            end
            if (psel && penable && pready && paddr == CAP_ADDR) begin
                if (pwrite) begin
                    cap_reg = pwdata[CNT_W-1:0];
                end else if (prdata[CNT_W-1:0] !== cap_reg) begin
                    note_error($sformatf("capacity readback: expected %0d, got %0d",
                                         cap_reg, prdata[CNT_W-1:0]));
                end
            end
            if (start && !busy)
                replies_due.push_back(apply_request(i_req_type, i_push_data, i_entry_index));
        end
        o_pending = replies_due.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the circular FIFO queue core: directed corner
// requests, a full fill and drain of the store, then random request mixes
// under a series of capacity settings, with random gaps on the request side.
// ----------------------------------------------------------------------------
module tb;
    import cfq_pkg::*;

    localparam int unsigned       CYCLE_LIMIT = 500000;
    localparam logic [APB_AW-1:0] CAP_ADDR    = '0;
    localparam int unsigned       REQ_TOP     = (1 << REQ_W) - 1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type;
    logic [31:0]           i_push_data;
    logic [IDX_W-1:0]      i_entry_index;
    logic                  o_result_valid;
    logic [31:0]           o_read_data;
    logic [STAT_W-1:0]     o_status;
    logic [CNT_W-1:0]      o_fill_count;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int unsigned errors;
    int unsigned pending;
    int unsigned cycles;
    int unsigned burst_left;
    bit          quiet;

    circular_fifo_queue_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_push_data    (i_push_data),
        .i_entry_index  (i_entry_index),
        .o_result_valid (o_result_valid),
        .o_read_data    (o_read_data),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    cfq_checker #(.CAP_ADDR(CAP_ADDR)) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_push_data    (i_push_data),
        .i_entry_index  (i_entry_index),
        .o_result_valid (o_result_valid),
        .o_read_data    (o_read_data),
        .o_status       (o_status),
        .o_fill_count   (o_fill_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // one request word; start stays high until the accepting edge
    task automatic issue(input logic [REQ_W-1:0] rt, input logic [31:0] word,
                         input logic [IDX_W-1:0] idx);
        int unsigned gap;
        if (burst_left == 0) begin
            quiet      = ($urandom_range(0, 3) == 0);
            burst_left = $urandom_range(10, 60);
        end
        burst_left--;
        gap = quiet ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start         = 1'b1;
        i_req_type    = rt;
        i_push_data   = word;
        i_entry_index = idx;
        do @(posedge i_clk); while (busy);
    endtask

    // push_pct sets how hard the mix leans toward filling the queue
    task automatic random_request(input int unsigned push_pct);
        int unsigned      roll;
        logic [REQ_W-1:0] rt;
        logic [IDX_W-1:0] idx;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            rt = REQ_W'($urandom_range(int'(REQ_OFFSET) + 1, REQ_TOP));
        end else if (roll < 3 + push_pct) begin
            rt = REQ_PUSH;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 45)      rt = REQ_POP;
            else if (roll < 60) rt = REQ_PEEK_F;
            else if (roll < 75) rt = REQ_PEEK_B;
            else                rt = REQ_OFFSET;
        end
        idx = $urandom_range(0, 1) ? IDX_W'($urandom_range(0, 7)) : IDX_W'($urandom);
        issue(rt, $urandom, idx);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = CAP_ADDR;
        pwdata  = {(APB_DW-CNT_W)'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin
        logic [CNT_W-1:0] caps [8];
        logic [CNT_W-1:0] new_cap;
        int unsigned      push_pct;

        caps = '{9'd1, 9'd0, 9'd511, 9'd3, 9'd256, 9'd40, 9'd257, 9'd128};
        cycles        = 0;
        burst_left    = 0;
        quiet         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = REQ_PUSH;
        i_push_data   = '0;
        i_entry_index = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = CAP_ADDR;
        pwdata        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corner requests at the reset capacity: empty reads, extremes, unused codes
        issue(REQ_POP,    $urandom, IDX_W'($urandom));
        issue(REQ_PEEK_F, $urandom, IDX_W'($urandom));
        issue(REQ_PEEK_B, $urandom, IDX_W'($urandom));
        issue(REQ_OFFSET, $urandom, '0);
        issue(REQ_PUSH,   32'h0000_0000, IDX_W'($urandom));
        issue(REQ_PUSH,   32'hFFFF_FFFF, IDX_W'($urandom));
        issue(REQ_PUSH,   32'hA5A5_A5A5, IDX_W'($urandom));
        issue(REQ_PEEK_F, $urandom, IDX_W'($urandom));
        issue(REQ_PEEK_B, $urandom, IDX_W'($urandom));
        issue(REQ_OFFSET, $urandom, 8'd0);
        issue(REQ_OFFSET, $urandom, 8'd2);
        issue(REQ_OFFSET, $urandom, 8'd3);
        issue(REQ_OFFSET, $urandom, 8'hFF);
        for (int k = 1; k <= REQ_TOP - int'(REQ_OFFSET); k++)
            issue(REQ_OFFSET + REQ_W'(k), $urandom, IDX_W'($urandom));
        repeat (4) issue(REQ_POP, $urandom, IDX_W'($urandom));

        // fill every slot of the store once, so later capacity moves never
        // land a read on an entry that was never written
        wait_drained();
        apb_access(1'b1, 9'd256);
        apb_access(1'b0, '0);
        repeat (257) issue(REQ_PUSH, $urandom, IDX_W'($urandom));
        issue(REQ_OFFSET, $urandom, 8'hFF);
        issue(REQ_PEEK_B, $urandom, IDX_W'($urandom));
        repeat (257) issue(REQ_POP, $urandom, IDX_W'($urandom));

        // capacity changes land with entries still held
        for (int ph = 0; ph < 10; ph++) begin
            wait_drained();
            new_cap = (ph < 8) ? caps[ph] : CNT_W'($urandom_range(1, 511));
            apb_access(1'b1, new_cap);
            apb_access(1'b0, '0);
            push_pct = 45;
            for (int n = 0; n < 125; n++) begin
                if (n % 32 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       push_pct = 20;
                        1:       push_pct = 45;
                        default: push_pct = 70;
                    endcase
                end
                if ($urandom_range(0, 199) == 0) wait_drained();
                random_request(push_pct);
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
